// ===== sv/sim3q_pkg.sv =====
// Shared types and constants for the quaternion similarity transform unit.
package sim3q_pkg;

    // Commands carried in the command field of an input item.
    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_PLANE = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_QUAT_W  = 3'd0;
    localparam logic [2:0] CFG_QUAT_X  = 3'd1;
    localparam logic [2:0] CFG_QUAT_Y  = 3'd2;
    localparam logic [2:0] CFG_QUAT_Z  = 3'd3;
    localparam logic [2:0] CFG_SCALE   = 3'd4;
    localparam logic [2:0] CFG_SHIFT_X = 3'd5;
    localparam logic [2:0] CFG_SHIFT_Y = 3'd6;
    localparam logic [2:0] CFG_SHIFT_Z = 3'd7;

    // Q2.30 one and Q16.16 one.
    localparam logic signed [31:0] QUAT_ONE  = 32'sd1073741824;
    localparam logic signed [31:0] SCALE_ONE = 32'sd65536;

    // Number of register stages from input to output.
    localparam int unsigned LATENCY = 7;

    typedef struct packed {
        logic               command;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_dist;
    } t_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_dist;
        logic               overflow;
    } t_result;

endpackage

// ===== sv/similarity_transform_3d_quaternion_unit.sv =====
// Top level: seven-stage pipelined quaternion similarity transform.
//
// Each item is a point (command 0) or a plane (command 1) in Q16.16. A point is
// rotated by the configured Q2.30 quaternion as v + 2w(u x v) + 2u x (u x v),
// multiplied by the Q16.16 scale and moved by the translation. A plane keeps its
// rotated normal and gets distance shift.n' + scale*in_dist. All roundings are
// round half up; results saturate to 32 bits and set overflow. The block takes
// one item per cycle while o_stall is low and returns each result from the
// stage 7 output register; the stages hold four multiplier ranks (u x v, the
// second cross product with w*c, the scale product, the plane dot product),
// each followed by a register, plus the rounding and saturation stages around
// them. Every stage holds its own valid bit: a stage with a bubble keeps loading
// while the output waits, so o_stall rises only once the whole pipeline is full.
// Quaternion components are clamped to [-1.0, 1.0] as they are written.
// Write configuration only while no item is in flight.
module similarity_transform_3d_quaternion_unit
    import sim3q_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_valid,
    output logic               o_stall,
    input  t_item              i_item,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output t_result            o_result,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic signed [31:0] i_cfg_data
);

    // Cyclic neighbors of each component for the cross products.
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    localparam logic signed [63:0] HALF30_64 = 64'sd536870912;
    localparam logic signed [65:0] HALF30_66 = 66'sd536870912;
    localparam logic signed [65:0] HALF16_66 = 66'sd32768;
    localparam logic signed [37:0] VMAX      = 38'sd4294967295;
    localparam logic signed [31:0] MAX32     = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32     = 32'sh80000000;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] r_quat_w;
    logic signed [31:0] r_quat_u [3];
    logic signed [31:0] r_scale;
    logic signed [31:0] r_shift [3];
    logic signed [31:0] n_quat;

    // Clamp a quaternion component to [-1.0, 1.0] on its way in.
    always_comb begin
        if (i_cfg_data > QUAT_ONE) begin
            n_quat = QUAT_ONE;
        end else if (i_cfg_data < -QUAT_ONE) begin
            n_quat = -QUAT_ONE;
        end else begin
            n_quat = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat_w    <= QUAT_ONE;
            r_quat_u[0] <= '0;
            r_quat_u[1] <= '0;
            r_quat_u[2] <= '0;
            r_scale     <= SCALE_ONE;
            r_shift[0]  <= '0;
            r_shift[1]  <= '0;
            r_shift[2]  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUAT_W:  r_quat_w    <= n_quat;
                CFG_QUAT_X:  r_quat_u[0] <= n_quat;
                CFG_QUAT_Y:  r_quat_u[1] <= n_quat;
                CFG_QUAT_Z:  r_quat_u[2] <= n_quat;
                CFG_SCALE:   r_scale     <= i_cfg_data;
                CFG_SHIFT_X: r_shift[0]  <= i_cfg_data;
                CFG_SHIFT_Y: r_shift[1]  <= i_cfg_data;
                CFG_SHIFT_Z: r_shift[2]  <= i_cfg_data;
                default:     r_scale     <= r_scale;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic [LATENCY:1] r_vld;
    logic [LATENCY:1] rdy;

    always_comb begin
        rdy[LATENCY] = !r_vld[LATENCY] || !i_stall;
        for (int k = LATENCY - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[1];
    assign o_valid = r_vld[LATENCY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= LATENCY; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: products of u x v
    // ------------------------------------------------------------------
    logic signed [31:0] in_v [3];
    logic signed [63:0] n_s1_pa [3];
    logic signed [63:0] n_s1_pb [3];
    logic signed [63:0] r_s1_pa [3];
    logic signed [63:0] r_s1_pb [3];
    logic signed [31:0] r_s1_v  [3];
    logic signed [31:0] r_s1_dist;
    logic               r_s1_cmd;

    assign in_v[0] = i_item.in_x;
    assign in_v[1] = i_item.in_y;
    assign in_v[2] = i_item.in_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1_pa[i] = 64'(r_quat_u[NXT[i]]) * 64'(in_v[PRV[i]]);
            n_s1_pb[i] = 64'(r_quat_u[PRV[i]]) * 64'(in_v[NXT[i]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1_pa   <= n_s1_pa;
            r_s1_pb   <= n_s1_pb;
            r_s1_v    <= in_v;
            r_s1_dist <= i_item.in_dist;
            r_s1_cmd  <= i_item.command;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round c = u x v to Q16.16 (34 bits covers |c| <= 2^32)
    // ------------------------------------------------------------------
    logic signed [63:0] s2_sum [3];
    logic signed [33:0] n_s2_c [3];
    logic signed [33:0] r_s2_c [3];
    logic signed [31:0] r_s2_v [3];
    logic signed [31:0] r_s2_dist;
    logic               r_s2_cmd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2_sum[i] = r_s1_pa[i] - r_s1_pb[i] + HALF30_64;
            n_s2_c[i] = $signed(s2_sum[i][63:30]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_s2_c    <= n_s2_c;
            r_s2_v    <= r_s1_v;
            r_s2_dist <= r_s1_dist;
            r_s2_cmd  <= r_s1_cmd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: products of w*c and u x c
    // ------------------------------------------------------------------
    logic signed [65:0] n_s3_m0 [3];
    logic signed [65:0] n_s3_m1 [3];
    logic signed [65:0] n_s3_m2 [3];
    logic signed [65:0] r_s3_m0 [3];
    logic signed [65:0] r_s3_m1 [3];
    logic signed [65:0] r_s3_m2 [3];
    logic signed [31:0] r_s3_v  [3];
    logic signed [31:0] r_s3_dist;
    logic               r_s3_cmd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s3_m0[i] = 66'(r_quat_w) * 66'(r_s2_c[i]);
            n_s3_m1[i] = 66'(r_quat_u[NXT[i]]) * 66'(r_s2_c[PRV[i]]);
            n_s3_m2[i] = 66'(r_quat_u[PRV[i]]) * 66'(r_s2_c[NXT[i]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s3_m0   <= n_s3_m0;
            r_s3_m1   <= n_s3_m1;
            r_s3_m2   <= n_s3_m2;
            r_s3_v    <= r_s2_v;
            r_s3_dist <= r_s2_dist;
            r_s3_cmd  <= r_s2_cmd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round d, form v' = v + 2d and hold it to +-(2^32 - 1)
    // ------------------------------------------------------------------
    logic signed [65:0] s4_sum [3];
    logic signed [35:0] s4_d   [3];
    logic signed [37:0] s4_vp  [3];
    logic signed [33:0] n_s4_r [3];
    logic               n_s4_ov;
    logic signed [33:0] r_s4_r [3];
    logic               r_s4_ov;
    logic signed [31:0] r_s4_dist;
    logic               r_s4_cmd;

    always_comb begin
        n_s4_ov = 1'b0;
        for (int i = 0; i < 3; i++) begin
            s4_sum[i] = r_s3_m0[i] + r_s3_m1[i] - r_s3_m2[i] + HALF30_66;
            s4_d[i]   = $signed(s4_sum[i][65:30]);
            s4_vp[i]  = 38'(r_s3_v[i]) + 38'(s4_d[i]) + 38'(s4_d[i]);
            if (s4_vp[i] > VMAX) begin
                n_s4_r[i] = 34'(VMAX);
                n_s4_ov   = 1'b1;
            end else if (s4_vp[i] < -VMAX) begin
                n_s4_r[i] = 34'(-VMAX);
                n_s4_ov   = 1'b1;
            end else begin
                n_s4_r[i] = 34'(s4_vp[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_s4_r    <= n_s4_r;
            r_s4_ov   <= n_s4_ov;
            r_s4_dist <= r_s3_dist;
            r_s4_cmd  <= r_s3_cmd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: scale product for points, saturated normal for planes
    // ------------------------------------------------------------------
    logic signed [65:0] n_s5_ps [3];
    logic signed [31:0] n_s5_rs [3];
    logic               s5_sat;
    logic signed [65:0] r_s5_ps [3];
    logic signed [31:0] r_s5_rs [3];
    logic               r_s5_ov;
    logic signed [31:0] r_s5_dist;
    logic               r_s5_cmd;

    always_comb begin
        s5_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_s5_ps[i] = 66'(r_scale) * 66'(r_s4_r[i]);
            if ((r_s4_r[i][33:31] == 3'b000) || (r_s4_r[i][33:31] == 3'b111)) begin
                n_s5_rs[i] = r_s4_r[i][31:0];
            end else begin
                n_s5_rs[i] = r_s4_r[i][33] ? MIN32 : MAX32;
                s5_sat     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_s5_ps   <= n_s5_ps;
            r_s5_rs   <= n_s5_rs;
            r_s5_ov   <= r_s4_ov || ((r_s4_cmd == CMD_PLANE) && s5_sat);
            r_s5_dist <= r_s4_dist;
            r_s5_cmd  <= r_s4_cmd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: round and translate points; dot product terms for planes
    // ------------------------------------------------------------------
    logic signed [65:0] s6_rnd [3];
    logic signed [49:0] n_s6_q [3];
    logic signed [63:0] n_s6_t [4];
    logic signed [49:0] r_s6_q [3];
    logic signed [63:0] r_s6_t [4];
    logic signed [31:0] r_s6_rs [3];
    logic               r_s6_ov;
    logic               r_s6_cmd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s6_rnd[i] = r_s5_ps[i] + HALF16_66;
            n_s6_q[i] = $signed(s6_rnd[i][65:16]) + 50'(r_shift[i]);
            n_s6_t[i] = 64'(r_shift[i]) * 64'(r_s5_rs[i]);
        end
        n_s6_t[3] = 64'(r_scale) * 64'(r_s5_dist);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_s6_q   <= n_s6_q;
            r_s6_t   <= n_s6_t;
            r_s6_rs  <= r_s5_rs;
            r_s6_ov  <= r_s5_ov;
            r_s6_cmd <= r_s5_cmd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: saturate, sum the plane distance, drive the output register
    // ------------------------------------------------------------------
    logic signed [31:0] s7_pq [3];
    logic               s7_psat;
    logic signed [65:0] s7_dsum;
    logic signed [49:0] s7_dr;
    logic signed [31:0] s7_dist;
    logic               s7_dsat;
    t_result            n_out;
    t_result            r_out;

    always_comb begin
        s7_psat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if ((r_s6_q[i][49:31] == '0) || (r_s6_q[i][49:31] == '1)) begin
                s7_pq[i] = r_s6_q[i][31:0];
            end else begin
                s7_pq[i] = r_s6_q[i][49] ? MIN32 : MAX32;
                s7_psat  = 1'b1;
            end
        end

        s7_dsum = 66'(r_s6_t[0]) + 66'(r_s6_t[1]) + 66'(r_s6_t[2]) + 66'(r_s6_t[3])
                + HALF16_66;
        s7_dr   = $signed(s7_dsum[65:16]);
        if ((s7_dr[49:31] == '0) || (s7_dr[49:31] == '1)) begin
            s7_dist = s7_dr[31:0];
            s7_dsat = 1'b0;
        end else begin
            s7_dist = s7_dr[49] ? MIN32 : MAX32;
            s7_dsat = 1'b1;
        end

        if (r_s6_cmd == CMD_PLANE) begin
            n_out.out_x    = r_s6_rs[0];
            n_out.out_y    = r_s6_rs[1];
            n_out.out_z    = r_s6_rs[2];
            n_out.out_dist = s7_dist;
            n_out.overflow = r_s6_ov || s7_dsat;
        end else begin
            n_out.out_x    = s7_pq[0];
            n_out.out_y    = s7_pq[1];
            n_out.out_z    = s7_pq[2];
            n_out.out_dist = '0;
            n_out.overflow = r_s6_ov || s7_psat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

// ===== sv/sim3q_checker.sv =====
// Port-level assertion checker for the similarity transform unit, with its bind.
module sim3q_checker
    import sim3q_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_valid,
    input logic    o_stall,
    input logic    o_valid,
    input logic    i_stall,
    input t_result o_result
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // An open output never back-pressures the input.
    a_stall_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    // An accepted item reaches the output after the pipeline latency when the output is not stalled.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall
        ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted item did not arrive at the output in time");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
        else $error("stalled result changed or dropped");

endmodule

bind similarity_transform_3d_quaternion_unit sim3q_checker u_sim3q_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_result   (o_result)
);

// ===== tb/tb_similarity_transform_3d_quaternion_unit.sv =====
// Self-checking testbench for the quaternion similarity transform unit.
module tb_similarity_transform_3d_quaternion_unit;
    import sim3q_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Wide enough to carry every intermediate product and sum exactly.
    typedef logic signed [95:0] wide_t;
    typedef logic signed [31:0] reg_set_t [8];

    localparam int NUM_REGS = 8;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam wide_t HI32 = 96'sd2147483647;
    localparam wide_t LO32 = -96'sd2147483648;
    // Rotated vector components are held to +-(2^32 - 1).
    localparam wide_t VEC_LIM = 96'sd4294967295;

    localparam int IDLE_PCT = 18;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int RANDOM_PHASES = 10;
    // Both sides run without idling while this range of items passes.
    localparam int QUIET_FROM = 900;
    localparam int QUIET_TO = 1100;
    // Long result hold-off, started once this many results have come.
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 30;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    o_stall;
    t_item   i_item = '0;
    logic    o_valid;
    logic    i_stall = 1'b0;
    t_result o_result;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic signed [31:0] i_cfg_data = '0;

    // Items waiting to be offered, and the results predicted for accepted items.
    t_item    queued_items[$];
    t_result  predicted_results[$];
    // Local copy of the transform registers, kept in step with every write.
    reg_set_t xform_reg;

    bit item_taken = 1'b0;
    int items_sent = 0;
    int results_seen = 0;
    int point_count = 0;
    int plane_count = 0;
    int sat_count = 0;
    int backpressure_cycles = 0;
    int settings_used = 0;
    int mismatch_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    similarity_transform_3d_quaternion_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Transform predictor
    // ------------------------------------------------------------------

    // Round half up: add half an LSB of the target, then floor.
    function automatic wide_t round_shift(input wide_t x, input int unsigned k);
        wide_t half;
        half = wide_t'(1) <<< (k - 1);
        return (x + half) >>> k;
    endfunction

    function automatic wide_t clamp_wide(input wide_t x, input wide_t lim_lo,
                                         input wide_t lim_hi, inout logic sat);
        if (x < lim_lo) begin
            sat = 1'b1;
            return lim_lo;
        end
        if (x > lim_hi) begin
            sat = 1'b1;
            return lim_hi;
        end
        return x;
    endfunction

    // Quaternion components are limited to [-1.0, 1.0]; this never flags overflow.
    function automatic wide_t quat_term(input int idx);
        wide_t q;
        q = wide_t'(xform_reg[idx]);
        if (q > wide_t'(QUAT_ONE))
            return wide_t'(QUAT_ONE);
        if (q < -wide_t'(QUAT_ONE))
            return -wide_t'(QUAT_ONE);
        return q;
    endfunction

    // Rotate as v + 2(w*c + u x c) with c = u x v, then scale and shift a point,
    // or keep the rotated normal of a plane and rebuild its distance.
    function automatic t_result transform_item(input t_item it);
        wide_t   v[3], u[3], c[3], d[3], r[3], res[4];
        wide_t   w, scl, acc;
        logic    sat;
        int      j, k;
        t_result t;
        sat = 1'b0;
        v[0] = wide_t'(it.in_x);
        v[1] = wide_t'(it.in_y);
        v[2] = wide_t'(it.in_z);
        w = quat_term(int'(CFG_QUAT_W));
        for (int i = 0; i < 3; i++)
            u[i] = quat_term(int'(CFG_QUAT_X) + i);
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            c[i] = round_shift(u[j] * v[k] - u[k] * v[j], 30);
        end
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            d[i] = round_shift(w * c[i] + u[j] * c[k] - u[k] * c[j], 30);
        end
        for (int i = 0; i < 3; i++)
            r[i] = clamp_wide(v[i] + 2 * d[i], -VEC_LIM, VEC_LIM, sat);
        scl = wide_t'(xform_reg[CFG_SCALE]);
        if (it.command == CMD_POINT) begin
            for (int i = 0; i < 3; i++)
                res[i] = clamp_wide(((scl * r[i] + 32768) >>> 16)
                                    + wide_t'(xform_reg[int'(CFG_SHIFT_X) + i]),
                                    LO32, HI32, sat);
            res[3] = '0;
        end else begin
            for (int i = 0; i < 3; i++)
                res[i] = clamp_wide(r[i], LO32, HI32, sat);
            // The dot product uses the saturated normal that goes out.
            acc = scl * wide_t'(it.in_dist);
            for (int i = 0; i < 3; i++)
                acc = acc + wide_t'(xform_reg[int'(CFG_SHIFT_X) + i]) * res[i];
            res[3] = clamp_wide(round_shift(acc, 16), LO32, HI32, sat);
        end
        t.out_x    = res[0][31:0];
        t.out_y    = res[1][31:0];
        t.out_z    = res[2][31:0];
        t.out_dist = res[3][31:0];
        t.overflow = sat;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic signed [31:0] small_val(input int unsigned mag);
        return int'($urandom_range(2 * mag)) - int'(mag);
    endfunction

    // Mix of extremes, full-range words and modest values that stay in range.
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(9))
            0:       return MAX32;
            1:       return MIN32;
            2, 3:    return $urandom;
            4:       return small_val(1);
            default: return small_val(32'h10_0000);
        endcase
    endfunction

    function automatic reg_set_t random_setting();
        reg_set_t s;
        for (int q = int'(CFG_QUAT_W); q <= int'(CFG_QUAT_Z); q++) begin
            case ($urandom_range(7))
                0:       s[q] = QUAT_ONE;
                1:       s[q] = -QUAT_ONE;
                2:       s[q] = '0;
                default: s[q] = 32'(longint'($urandom_range(32'h8000_0000))
                                    - longint'(QUAT_ONE));
            endcase
        end
        case ($urandom_range(3))
            0:       s[CFG_SCALE] = SCALE_ONE;
            1:       s[CFG_SCALE] = $urandom;
            default: s[CFG_SCALE] = small_val(32'h4_0000);
        endcase
        for (int q = int'(CFG_SHIFT_X); q <= int'(CFG_SHIFT_Z); q++)
            s[q] = ($urandom_range(3) == 0) ? 32'($urandom) : small_val(32'h100_0000);
        return s;
    endfunction

    task automatic push_item(input logic cmd, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z,
                             input logic signed [31:0] dist_val);
        t_item it;
        it.command = cmd;
        it.in_x    = x;
        it.in_y    = y;
        it.in_z    = z;
        it.in_dist = dist_val;
        queued_items.push_back(it);
    endtask

    // Corners of the coordinate range for both commands, plus a unit normal.
    task automatic push_directed();
        push_item(CMD_POINT, 0, 0, 0, 0);
        push_item(CMD_POINT, MAX32, MAX32, MAX32, MAX32);
        push_item(CMD_POINT, MIN32, MIN32, MIN32, MIN32);
        push_item(CMD_PLANE, MAX32, MIN32, MAX32, MAX32);
        push_item(CMD_PLANE, MIN32, MAX32, MIN32, MIN32);
        push_item(CMD_PLANE, SCALE_ONE, 0, 0, SCALE_ONE);
    endtask

    // Write all registers back to back; the block must be idle.
    task automatic apply_setting(input reg_set_t setting);
        for (int idx = 0; idx < NUM_REGS; idx++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(idx);
            i_cfg_data <= setting[idx];
            xform_reg[idx] = setting[idx];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Hold the sender until every predicted result has come, then let the
    // pipeline settle for its full depth.
    task automatic wait_until_idle();
        while (queued_items.size() != 0 || i_valid || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("t=%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: accept at the rising edge, drive at the falling edge
    // ------------------------------------------------------------------

    // Record each accepted item and predict its result right away.
    always @(posedge i_clk) begin
        item_taken = 1'b0;
        if (i_rst_n && i_valid && o_stall == 1'b0) begin
            item_taken = 1'b1;
            predicted_results.push_back(transform_item(i_item));
            items_sent++;
            if (i_item.command == CMD_POINT)
                point_count++;
            else
                plane_count++;
        end
        if (i_rst_n && i_valid && o_stall == 1'b1)
            backpressure_cycles++;
    end

    // Hold the payload while stalled; otherwise offer the next item or idle.
    always @(negedge i_clk) begin
        if (!i_valid || item_taken) begin
            if (queued_items.size() != 0 &&
                ((items_sent >= QUIET_FROM && items_sent < QUIET_TO) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
                i_item  <= queued_items.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Random stalls, one long hold-off that backs the pipeline up, and a quiet
    // stretch with no stalls at all.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Compare each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            results_seen++;
            if (o_result.overflow === 1'b1)
                sat_count++;
            if (predicted_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("t=%0t unexpected result: expected none, actual %h",
                             $time, o_result);
            end else begin
                want = predicted_results.pop_front();
                check_field("out_x", want.out_x, o_result.out_x);
                check_field("out_y", want.out_y, o_result.out_y);
                check_field("out_z", want.out_z, o_result.out_z);
                check_field("out_dist", want.out_dist, o_result.out_dist);
                check_field("overflow", 32'(want.overflow), 32'(o_result.overflow));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        reg_set_t reset_setting;
        reg_set_t corner_setting;
        reg_set_t clamp_setting;
        // Register order: quat w, x, y, z, scale, shift x, y, z.
        reset_setting  = '{QUAT_ONE, 0, 0, 0, SCALE_ONE, 0, 0, 0};
        // Non-unit quaternion at its limits, most negative scale, extreme shifts.
        corner_setting = '{-QUAT_ONE, QUAT_ONE, -QUAT_ONE, QUAT_ONE,
                           MIN32, MAX32, MIN32, 0};
        // Quaternion words beyond +-1.0, clamped by the block; largest scale.
        clamp_setting  = '{MAX32, MIN32, MAX32, 0, MAX32, MIN32, MAX32, 1};
        xform_reg = reset_setting;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: first with the reset transform, then the two
        // extreme register settings.
        push_directed();
        wait_until_idle();
        apply_setting(corner_setting);
        push_directed();
        wait_until_idle();
        apply_setting(clamp_setting);
        push_directed();
        wait_until_idle();

        // Random phases, each under a fresh setting; the last one returns to
        // the reset values.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1)
                apply_setting(reset_setting);
            else
                apply_setting(random_setting());
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_item(($urandom_range(1) == 0) ? CMD_POINT : CMD_PLANE,
                          pick_coord(), pick_coord(), pick_coord(), pick_coord());
            wait_until_idle();
        end

        $display("Run covered %0d points and %0d planes under %0d register settings;",
                 point_count, plane_count, settings_used + 1);
        $display("%0d results saturated, input backed up for %0d cycles.",
                 sat_count, backpressure_cycles);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Timeout with %0d results still outstanding", predicted_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
